/* rtl/sfr_pkg.sv */
// Package for the frame receiver: frame layout, gap rule constants and field widths.
// No dependencies; used by sbus_frame_receiver_core.
package sfr_pkg;

  localparam int unsigned TickWidth   = 24;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned StoreDepth  = 24;
  localparam int unsigned PayloadLast = 22;
  localparam int unsigned ChanWidth   = 11;
  localparam int unsigned IdxWidth    = 4;
  localparam int unsigned AccWidth    = 18;
  localparam int unsigned CntWidth    = 5;
  localparam int unsigned MemAddrW    = 6;
  localparam int unsigned MemDepth    = 64;

  localparam logic [7:0]           StartByte    = 8'h0f;
  localparam logic [15:0]          GapLimitRst  = 16'h1690;
  localparam logic [TickWidth-1:0] ReloadRst    = {TickWidth{1'b1}};
  localparam logic [15:0]          OverrunGap   = 16'hFFFE;
  localparam logic [15:0]          GapSat       = 16'hFFFF;
  localparam logic [PosWidth-1:0]  LastPos      = PosWidth'(StoreDepth);
  localparam logic [IdxWidth-1:0]  LastChannel  = {IdxWidth{1'b1}};

  localparam logic RegGapLimit = 1'b0;
  localparam logic RegReload   = 1'b1;

  typedef struct packed {
    logic [7:0]            footer;
    logic [ChanWidth-1:0]  value;
    logic [IdxWidth-1:0]   index;
  } out_item_t;

endpackage

/* rtl/sbus_frame_receiver_core.sv */
// Frame receiver: one byte per request, gap check, banked frame store and channel unpacker.
// Depends on sfr_pkg.
// Once the last frame byte is accepted its bank is marked full and the unpacker starts on it;
// the 22 payload byte reads pace the 16 channels, which leave through the output register.
// Throughput: one input byte per cycle; input stalls only while both store banks hold
// frames not yet unpacked. Reset (rst_ni low, asynchronous) returns to hunting with both
// banks free and registers at their reset values; the store itself is not cleared.
module sbus_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [7:0] rx_byte, [31:8] tick_now
  input  logic        s_axis_tuser_i,   // [0] overrun
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [3:0] channel_index, [14:4] channel_value,
                                        // [22:15] footer_byte, [23] zero
  output logic        m_axis_tlast_o,   // last_channel
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned TW = sfr_pkg::TickWidth;

  logic [15:0]   gap_limit_q;
  logic [TW-1:0] reload_q;

  logic [sfr_pkg::PosWidth-1:0] pos_q;
  logic                         failed_q;
  logic [TW-1:0]                prev_tick_q;
  logic                         wb_q;
  logic [1:0]                   full_q;
  logic [7:0]                   footer_q [2];

  logic [7:0] mem_q [sfr_pkg::MemDepth];
  logic [7:0] rdata_q;
  logic       byte_v_q;

  logic                          active_q;
  logic                          rb_q;
  logic [sfr_pkg::CntWidth-1:0]  rd_addr_q;
  logic [sfr_pkg::AccWidth-1:0]  acc_q;
  logic [sfr_pkg::CntWidth-1:0]  cnt_q;
  logic [sfr_pkg::IdxWidth-1:0]  ch_q;

  logic               out_v_q;
  sfr_pkg::out_item_t out_q;
  logic               out_last_q;

  // configuration port
  logic cfg_we;
  assign cfg_we   = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_comb begin
    unique case (paddr_i[2])
      sfr_pkg::RegGapLimit: prdata_o = {16'b0, gap_limit_q};
      sfr_pkg::RegReload:   prdata_o = 32'(reload_q);
      default:              prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= sfr_pkg::GapLimitRst;
      reload_q    <= sfr_pkg::ReloadRst;
    end else if (cfg_we) begin
      if (paddr_i[2] == sfr_pkg::RegGapLimit) begin
        gap_limit_q <= pwdata_i[15:0];
      end else begin
        reload_q <= pwdata_i[TW-1:0];
      end
    end
  end

  // input side: gap measure and store write
  logic [7:0]    rx_byte;
  logic [TW-1:0] tick_now;
  logic          hunting;
  logic          accept;
  logic          mem_we;
  logic [TW:0]   wrap_sum;
  logic [TW:0]   gap_wide;
  logic [15:0]   gap;
  logic          fail_now;
  logic [sfr_pkg::PosWidth-1:0] wr_idx;

  assign rx_byte  = s_axis_tdata_i[7:0];
  assign tick_now = s_axis_tdata_i[8 +: TW];
  assign hunting  = (pos_q == '0) || (pos_q > sfr_pkg::LastPos);
  assign s_axis_tready_o = hunting || !full_q[wb_q];
  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign mem_we   = accept & !hunting;
  assign wr_idx   = pos_q - sfr_pkg::PosWidth'(1);
  assign wrap_sum = {1'b0, prev_tick_q} + {1'b0, reload_q};

  always_comb begin
    if (prev_tick_q > tick_now) begin
      gap_wide = {1'b0, prev_tick_q - tick_now};
    end else if (wrap_sum >= {1'b0, tick_now}) begin
      gap_wide = wrap_sum - {1'b0, tick_now};
    end else begin
      gap_wide = (TW+1)'(sfr_pkg::GapSat);
    end
    priority if (s_axis_tuser_i) begin
      gap = sfr_pkg::OverrunGap;
    end else if (gap_wide > (TW+1)'(sfr_pkg::GapSat)) begin
      gap = sfr_pkg::GapSat;
    end else begin
      gap = gap_wide[15:0];
    end
  end

  assign fail_now = failed_q | (gap > gap_limit_q);

  // unpacker control
  logic                          out_free;
  logic                          emit_need;
  logic                          consume;
  logic                          emit_fire;
  logic                          rd_en;
  logic                          start;
  logic                          done;
  logic [sfr_pkg::AccWidth-1:0]  acc_new;

  assign out_free  = !out_v_q || m_axis_tready_i;
  assign emit_need = cnt_q >= sfr_pkg::CntWidth'(3);
  assign consume   = byte_v_q && (!emit_need || out_free);
  assign emit_fire = consume && emit_need;
  assign rd_en     = active_q && (rd_addr_q < sfr_pkg::CntWidth'(sfr_pkg::PayloadLast))
                     && (!byte_v_q || consume);
  assign start     = !active_q && full_q[rb_q];
  assign done      = emit_fire && (ch_q == sfr_pkg::LastChannel);
  assign acc_new   = acc_q | (sfr_pkg::AccWidth'(rdata_q) << cnt_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[{wb_q, wr_idx}] <= rx_byte;
    end
    if (rd_en) begin
      rdata_q <= mem_q[{rb_q, rd_addr_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      failed_q    <= 1'b0;
      prev_tick_q <= '0;
      wb_q        <= 1'b0;
    end else if (accept) begin
      prev_tick_q <= tick_now;
      if (hunting) begin
        if (rx_byte == sfr_pkg::StartByte) begin
          pos_q    <= sfr_pkg::PosWidth'(1);
          failed_q <= 1'b0;
        end else begin
          pos_q <= '0;
        end
      end else if (pos_q == sfr_pkg::LastPos) begin
        pos_q    <= '0;
        failed_q <= 1'b0;
        if (!fail_now) begin
          wb_q <= !wb_q;
        end
      end else begin
        pos_q    <= pos_q + sfr_pkg::PosWidth'(1);
        failed_q <= fail_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && (pos_q == sfr_pkg::LastPos)) begin
      footer_q[wb_q] <= rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 2'b00;
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (mem_we && (pos_q == sfr_pkg::LastPos) && !fail_now && (wb_q == 1'(b))) begin
          full_q[b] <= 1'b1;
        end else if (done && (rb_q == 1'(b))) begin
          full_q[b] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rb_q      <= 1'b0;
      rd_addr_q <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      ch_q      <= '0;
      byte_v_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_addr_q <= rd_addr_q + sfr_pkg::CntWidth'(1);
        byte_v_q  <= 1'b1;
      end else if (consume) begin
        byte_v_q <= 1'b0;
      end
      if (consume) begin
        if (emit_need) begin
          acc_q <= acc_new >> sfr_pkg::ChanWidth;
          cnt_q <= cnt_q - sfr_pkg::CntWidth'(3);
          ch_q  <= ch_q + sfr_pkg::IdxWidth'(1);
        end else begin
          acc_q <= acc_new;
          cnt_q <= cnt_q + sfr_pkg::CntWidth'(8);
        end
      end
      if (start) begin
        active_q  <= 1'b1;
        rd_addr_q <= '0;
        acc_q     <= '0;
        cnt_q     <= '0;
        ch_q      <= '0;
      end else if (done) begin
        active_q <= 1'b0;
        rb_q     <= !rb_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit_fire) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.index  <= ch_q;
      out_q.value  <= acc_new[sfr_pkg::ChanWidth-1:0];
      out_q.footer <= footer_q[rb_q];
      out_last_q   <= (ch_q == sfr_pkg::LastChannel);
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {1'b0, out_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> full_q[rb_q])
    else $error("unpacker runs on a free bank");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && active_q) |-> (wb_q != rb_q))
    else $error("frame write hits the bank being unpacked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_addr_q < sfr_pkg::CntWidth'(sfr_pkg::PayloadLast)))
    else $error("unpacker reads past the channel bytes");
`endif

endmodule
